// ----- design/opv_pkg.sv -----
// Shared constants and types for the orthonormal pair block.
package opv_pkg;

   localparam int IN_WIDTH_DEF = 32;
   localparam int OUT_FRAC_DEF = 30;

   // Operand slice width of the partial-product multiplier.
   localparam int LIMB_WIDTH = 32;
   // Register stages in one multiplier: partial products, then their sum.
   localparam int MUL_LATENCY = 2;

   // Axis with the smallest absolute component.
   typedef enum logic [2:0] {
      AXIS_X = 3'b001,
      AXIS_Y = 3'b010,
      AXIS_Z = 3'b100
   } axis_type;

   // Control that travels beside the data through the pipeline.
   typedef struct packed {
      logic     valid;
      logic     zero;
      axis_type k;
      logic     neg_a;
      logic     neg_b;
      logic     neg_k;
   } side_type;

endpackage

// ----- design/opv_mul.sv -----
// Two-stage unsigned multiplier built from partial products of 32-bit slices.
module opv_mul #(
   parameter int A_WIDTH = 64,
   parameter int B_WIDTH = 64
) (
   input  logic                       clock,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] p
);
   import opv_pkg::*;

   localparam int NA = (A_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int NB = (B_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int PW = (NA + NB) * LIMB_WIDTH;

   logic [NA*LIMB_WIDTH-1:0]     a_pad;
   logic [NB*LIMB_WIDTH-1:0]     b_pad;
   logic [2*LIMB_WIDTH-1:0]      pp_ff [NA*NB];
   logic [PW-1:0]                sum_in;
   logic [A_WIDTH+B_WIDTH-1:0]   p_ff;

   assign a_pad = (NA*LIMB_WIDTH)'(a);
   assign b_pad = (NB*LIMB_WIDTH)'(b);

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i*NB+j] <= a_pad[i*LIMB_WIDTH +: LIMB_WIDTH]
                           * b_pad[j*LIMB_WIDTH +: LIMB_WIDTH];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i*NB+j]) << (LIMB_WIDTH*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= sum_in[A_WIDTH+B_WIDTH-1:0];
   end

   assign p = p_ff;

endmodule

// ----- design/opv_rdiv.sv -----
// Pipelined root divider: q = round(sqrt(c2 / s) * 2^FRAC), one result bit per stage.
module opv_rdiv #(
   parameter int VAL_WIDTH = 64,
   parameter int FRAC      = 30
) (
   input  logic                 clock,
   input  logic [VAL_WIDTH-1:0] c2,
   input  logic [VAL_WIDTH-1:0] s,
   output logic [FRAC:0]        q
);
   localparam int NS = FRAC + 1;
   localparam int DW = VAL_WIDTH + 2*FRAC + 6;
   localparam int TW = VAL_WIDTH + FRAC + 4;

   // The residual d is c2*4^(FRAC+1) - (2q-1)^2*s and t is (2q-1)*s.
   // Setting bit j of q costs 2^(j+2)*t + 4^(j+1)*s of residual.
   logic [DW-1:0]        d_ff [NS];
   logic [TW-1:0]        t_ff [NS];
   logic [VAL_WIDTH-1:0] s_ff [NS];
   logic [FRAC:0]        q_ff [NS+1];

   always_ff @(posedge clock) begin
      d_ff[0] <= (DW'(c2) << (2*FRAC+2)) - DW'(s);
      t_ff[0] <= TW'(0) - TW'(s);
      s_ff[0] <= s;
      q_ff[0] <= '0;
   end

   for (genvar i = 0; i < NS; i++) begin : g_step
      localparam int J = FRAC - i;
      logic [DW-1:0] trial;
      logic          accept;
      logic [FRAC:0] q_next;

      always_comb begin
         trial  = d_ff[i] - (DW'($signed(t_ff[i])) << (J+2))
                - (DW'(s_ff[i]) << (2*J+2));
         accept = ~trial[DW-1];
         q_next = q_ff[i];
         q_next[J] = accept;
      end

      always_ff @(posedge clock) begin
         q_ff[i+1] <= q_next;
      end

      if (i < NS-1) begin : g_carry
         always_ff @(posedge clock) begin
            d_ff[i+1] <= accept ? trial : d_ff[i];
            t_ff[i+1] <= accept ? t_ff[i] + (TW'(s_ff[i]) << (J+1)) : t_ff[i];
            s_ff[i+1] <= s_ff[i];
         end
      end
   end

   assign q = q_ff[NS];

endmodule

// ----- design/orthonormal_pair_from_vector.sv -----
// Top level of the orthonormal pair block: two unit normals of one 3-D vector.
//
//   channel   direction  handshake                    word
//   request   in         start high, busy low         vec_x, vec_y, vec_z
//   response  out        rsp_valid, one cycle         first_*, second_*, status
//
// A new word is taken in every cycle; busy is high only during reset.
// On its way to the response, each word passes the OUT_FRAC + 1 stages of the
// root dividers, which produce one result bit each.
// Reset is synchronous and clears the valid bits of every stage.
// The receiver cannot stall, so the pipeline never holds.
module orthonormal_pair_from_vector #(
   parameter int IN_WIDTH = opv_pkg::IN_WIDTH_DEF,
   parameter int OUT_FRAC = opv_pkg::OUT_FRAC_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [IN_WIDTH-1:0] req_vec_x,
   input  logic signed [IN_WIDTH-1:0] req_vec_y,
   input  logic signed [IN_WIDTH-1:0] req_vec_z,
   output logic                       rsp_valid,
   output logic signed [OUT_FRAC+1:0] rsp_first_x,
   output logic signed [OUT_FRAC+1:0] rsp_first_y,
   output logic signed [OUT_FRAC+1:0] rsp_first_z,
   output logic signed [OUT_FRAC+1:0] rsp_second_x,
   output logic signed [OUT_FRAC+1:0] rsp_second_y,
   output logic signed [OUT_FRAC+1:0] rsp_second_z,
   output logic                       rsp_status
);
   import opv_pkg::*;

   localparam int W        = IN_WIDTH;
   localparam int OB       = OUT_FRAC + 2;
   localparam int SW       = 2 * W;
   localparam int PW       = 4 * W;
   localparam int UNIT_LAT = OUT_FRAC + 2;

   // Stage 0: the request word.
   logic [W-1:0] vx_ff, vy_ff, vz_ff;
   logic         v0_ff;

   // Stage 1: magnitudes and signs. The most negative input becomes the
   // magnitude 2^(W-1), which the unsigned W-bit magnitude holds.
   logic [W-1:0] mx_ff, my_ff, mz_ff;
   logic         nx_ff, ny_ff, nz_ff;
   logic         v1_ff;

   // Stage 2: smallest axis k and the other two axes a = k+1, b = k+2.
   logic [W-1:0] ma_ff, mb_ff, mk_ff;
   side_type     side2_ff, side2_in;
   logic [W-1:0] ma_in, mb_in, mk_in;

   // Squares of the three magnitudes.
   logic [SW-1:0] sa, sb, sk;
   side_type      sidea_ff [MUL_LATENCY];

   // Stage 5: s1 = a^2 + b^2 and the full squared length vv.
   logic [SW-1:0] s1_ff, vv_ff, sa5_ff, sb5_ff;
   side_type      side5_ff;

   // Products for the second normal.
   logic [PW-1:0] sask, sbsk, svv;
   logic [SW-1:0] sa_d_ff [MUL_LATENCY];
   logic [SW-1:0] sb_d_ff [MUL_LATENCY];
   logic [SW-1:0] s1_d_ff [MUL_LATENCY];
   logic [SW-1:0] vv_d_ff [MUL_LATENCY];
   side_type      sideb_ff [MUL_LATENCY];

   // Root divider results and the control beside them.
   logic [OUT_FRAC:0] q_n1a, q_n1b, q_n2k, q_n2a, q_n2b;
   side_type          sideu_ff [UNIT_LAT];
   side_type          sideo;

   // Response register.
   logic          rsp_valid_ff;
   logic [OB-1:0] fx_ff, fy_ff, fz_ff, sx_ff, sy_ff, sz_ff;
   logic          st_ff;
   logic [OB-1:0] fx_in, fy_in, fz_in, sx_in, sy_in, sz_in;
   logic [OB-1:0] n1a, n1b, n2k, n2a, n2b;

   function automatic logic [OB-1:0] with_sign(input logic [OUT_FRAC:0] mag, input logic neg);
      logic [OB-1:0] m;
      m = OB'(mag);
      return neg ? (OB'(0) - m) : m;
   endfunction

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff <= req_vec_x;
      vy_ff <= req_vec_y;
      vz_ff <= req_vec_z;
      nx_ff <= vx_ff[W-1];
      ny_ff <= vy_ff[W-1];
      nz_ff <= vz_ff[W-1];
      mx_ff <= vx_ff[W-1] ? (W'(0) - vx_ff) : vx_ff;
      my_ff <= vy_ff[W-1] ? (W'(0) - vy_ff) : vy_ff;
      mz_ff <= vz_ff[W-1] ? (W'(0) - vz_ff) : vz_ff;
   end

   // Ties go toward the later axis: x wins only when strictly smallest.
   always_comb begin
      side2_in.valid = v1_ff;
      side2_in.zero  = (mx_ff == '0) && (my_ff == '0) && (mz_ff == '0);
      if ((mx_ff < my_ff) && (mx_ff < mz_ff)) begin
         side2_in.k = AXIS_X;
      end else if (my_ff < mz_ff) begin
         side2_in.k = AXIS_Y;
      end else begin
         side2_in.k = AXIS_Z;
      end
      case (side2_in.k)
         AXIS_X: begin
            ma_in = my_ff; mb_in = mz_ff; mk_in = mx_ff;
            side2_in.neg_a = ny_ff; side2_in.neg_b = nz_ff; side2_in.neg_k = nx_ff;
         end
         AXIS_Y: begin
            ma_in = mz_ff; mb_in = mx_ff; mk_in = my_ff;
            side2_in.neg_a = nz_ff; side2_in.neg_b = nx_ff; side2_in.neg_k = ny_ff;
         end
         default: begin
            ma_in = mx_ff; mb_in = my_ff; mk_in = mz_ff;
            side2_in.neg_a = nx_ff; side2_in.neg_b = ny_ff; side2_in.neg_k = nz_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      mk_ff <= mk_in;
   end

   opv_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_sq_a (.clock(clock), .a(ma_ff), .b(ma_ff), .p(sa));
   opv_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_sq_b (.clock(clock), .a(mb_ff), .b(mb_ff), .p(sb));
   opv_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_sq_k (.clock(clock), .a(mk_ff), .b(mk_ff), .p(sk));

   // Both sums stay below 2^(2W): each square is at most 2^(2W-2).
   always_ff @(posedge clock) begin
      s1_ff  <= sa + sb;
      vv_ff  <= sa + sb + sk;
      sa5_ff <= sa;
      sb5_ff <= sb;
   end

   // k^2 at stage 5 is the length minus the pair sum.
   function automatic logic [SW-1:0] sk_d();
      return vv_ff - s1_ff;
   endfunction

   opv_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_mul_ak (.clock(clock), .a(sa5_ff), .b(sk_d()), .p(sask));
   opv_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_mul_bk (.clock(clock), .a(sb5_ff), .b(sk_d()), .p(sbsk));
   opv_mul #(.A_WIDTH(SW), .B_WIDTH(SW)) u_mul_sv (.clock(clock), .a(s1_ff), .b(vv_ff), .p(svv));

   always_ff @(posedge clock) begin
      sa_d_ff[0] <= sa5_ff;
      sb_d_ff[0] <= sb5_ff;
      s1_d_ff[0] <= s1_ff;
      vv_d_ff[0] <= vv_ff;
      for (int i = 1; i < MUL_LATENCY; i++) begin
         sa_d_ff[i] <= sa_d_ff[i-1];
         sb_d_ff[i] <= sb_d_ff[i-1];
         s1_d_ff[i] <= s1_d_ff[i-1];
         vv_d_ff[i] <= vv_d_ff[i-1];
      end
   end

   // First normal along v x e: its a part is v_b, its b part is -v_a.
   opv_rdiv #(.VAL_WIDTH(SW), .FRAC(OUT_FRAC)) u_n1a (
      .clock(clock), .c2(sb_d_ff[MUL_LATENCY-1]), .s(s1_d_ff[MUL_LATENCY-1]), .q(q_n1a));
   opv_rdiv #(.VAL_WIDTH(SW), .FRAC(OUT_FRAC)) u_n1b (
      .clock(clock), .c2(sa_d_ff[MUL_LATENCY-1]), .s(s1_d_ff[MUL_LATENCY-1]), .q(q_n1b));
   // Second normal along v(v.e) - e|v|^2. Its k part reduces to sqrt(s1 / vv).
   opv_rdiv #(.VAL_WIDTH(SW), .FRAC(OUT_FRAC)) u_n2k (
      .clock(clock), .c2(s1_d_ff[MUL_LATENCY-1]), .s(vv_d_ff[MUL_LATENCY-1]), .q(q_n2k));
   opv_rdiv #(.VAL_WIDTH(PW), .FRAC(OUT_FRAC)) u_n2a (
      .clock(clock), .c2(sask), .s(svv), .q(q_n2a));
   opv_rdiv #(.VAL_WIDTH(PW), .FRAC(OUT_FRAC)) u_n2b (
      .clock(clock), .c2(sbsk), .s(svv), .q(q_n2b));

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff <= '0;
         side5_ff <= '0;
         for (int i = 0; i < MUL_LATENCY; i++) begin
            sidea_ff[i] <= '0;
            sideb_ff[i] <= '0;
         end
         for (int i = 0; i < UNIT_LAT; i++) begin
            sideu_ff[i] <= '0;
         end
      end else begin
         side2_ff    <= side2_in;
         sidea_ff[0] <= side2_ff;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            sidea_ff[i] <= sidea_ff[i-1];
         end
         side5_ff    <= sidea_ff[MUL_LATENCY-1];
         sideb_ff[0] <= side5_ff;
         for (int i = 1; i < MUL_LATENCY; i++) begin
            sideb_ff[i] <= sideb_ff[i-1];
         end
         sideu_ff[0] <= sideb_ff[MUL_LATENCY-1];
         for (int i = 1; i < UNIT_LAT; i++) begin
            sideu_ff[i] <= sideu_ff[i-1];
         end
      end
   end

   assign sideo = sideu_ff[UNIT_LAT-1];

   always_comb begin
      n1a = with_sign(q_n1a, sideo.neg_b);
      n1b = with_sign(q_n1b, ~sideo.neg_a);
      n2k = with_sign(q_n2k, 1'b1);
      n2a = with_sign(q_n2a, sideo.neg_a ^ sideo.neg_k);
      n2b = with_sign(q_n2b, sideo.neg_b ^ sideo.neg_k);
      fx_in = '0; fy_in = '0; fz_in = '0;
      sx_in = '0; sy_in = '0; sz_in = '0;
      if (!sideo.zero) begin
         case (sideo.k)
            AXIS_X: begin
               fy_in = n1a; fz_in = n1b;
               sx_in = n2k; sy_in = n2a; sz_in = n2b;
            end
            AXIS_Y: begin
               fz_in = n1a; fx_in = n1b;
               sy_in = n2k; sz_in = n2a; sx_in = n2b;
            end
            AXIS_Z: begin
               fx_in = n1a; fy_in = n1b;
               sz_in = n2k; sx_in = n2a; sy_in = n2b;
            end
            default: begin
               fx_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sideo.valid;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fz_ff <= fz_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sz_ff <= sz_in;
      st_ff <= sideo.zero;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_first_x  = fx_ff;
   assign rsp_first_y  = fy_ff;
   assign rsp_first_z  = fz_ff;
   assign rsp_second_x = sx_ff;
   assign rsp_second_y = sy_ff;
   assign rsp_second_z = sz_ff;
   assign rsp_status   = st_ff;

endmodule

// ----- design/opv_checker.sv -----
// Port-level assertions for the orthonormal pair block, bound to its top level.
module opv_checker #(
   parameter int OUT_FRAC = 30
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [OUT_FRAC+1:0] rsp_first_x,
   input logic [OUT_FRAC+1:0] rsp_first_y,
   input logic [OUT_FRAC+1:0] rsp_first_z,
   input logic [OUT_FRAC+1:0] rsp_second_x,
   input logic [OUT_FRAC+1:0] rsp_second_y,
   input logic [OUT_FRAC+1:0] rsp_second_z,
   input logic                rsp_status
);
   localparam int OB  = OUT_FRAC + 2;
   localparam int LAT = OUT_FRAC + 11;

   logic acc_ff [LAT];

   function automatic logic in_unit(input logic [OB-1:0] v);
      return (v[OB-1] == v[OB-2]) || (v == {2'b01, {OUT_FRAC{1'b0}}});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            acc_ff[i] <= 1'b0;
         end
      end else begin
         acc_ff[0] <= start & ~busy;
         for (int i = 1; i < LAT; i++) begin
            acc_ff[i] <= acc_ff[i-1];
         end
      end
   end

   // Every accepted word comes out once, and no response comes out without one.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == acc_ff[LAT-1])
      else $error("response does not match an accepted request");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_first_x == '0) && (rsp_first_y == '0)
         && (rsp_first_z == '0) && (rsp_second_x == '0) && (rsp_second_y == '0)
         && (rsp_second_z == '0))
      else $error("zero-length response has nonzero components");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_unit(rsp_first_x) && in_unit(rsp_first_y) && in_unit(rsp_first_z)
         && in_unit(rsp_second_x) && in_unit(rsp_second_y) && in_unit(rsp_second_z))
      else $error("component outside the unit range");

   // The first normal has no part along the chosen axis.
   a_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_status) |->
         (rsp_first_x == '0) || (rsp_first_y == '0) || (rsp_first_z == '0))
      else $error("first normal has no zero component");

endmodule

bind orthonormal_pair_from_vector opv_checker #(.OUT_FRAC(OUT_FRAC)) u_opv_checker (.*);

// ----- test/tb_top.sv -----
// Testbench for the orthonormal pair block: directed and random vectors against exact math.
`timescale 1ns / 100ps

// The testbench drives vectors into the block and computes the two expected unit
// normals of each accepted vector in exact integer arithmetic. A monitor compares
// every response word, field by field, with the oldest expected pair.
module tb_top;
   import opv_pkg::*;

   localparam int VW = IN_WIDTH_DEF;
   localparam int FW = OUT_FRAC_DEF;
   // Response latency of the design.
   localparam int LATENCY = FW + 11;
   localparam int CYCLE_LIMIT = 400000;

   typedef bit [255:0] wide_type;

   // One expected response word.
   typedef struct {
      logic signed [FW+1:0] first [3];
      logic signed [FW+1:0] second [3];
      logic                 status;
   } normal_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VW-1:0] req_vec_x = '0;
   logic signed [VW-1:0] req_vec_y = '0;
   logic signed [VW-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic signed [FW+1:0] rsp_first_x, rsp_first_y, rsp_first_z;
   logic signed [FW+1:0] rsp_second_x, rsp_second_y, rsp_second_z;
   logic rsp_status;

   normal_pair_type pending_pairs [$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0;

   orthonormal_pair_from_vector uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid),
      .rsp_first_x(rsp_first_x), .rsp_first_y(rsp_first_y), .rsp_first_z(rsp_first_z),
      .rsp_second_x(rsp_second_x), .rsp_second_y(rsp_second_y),
      .rsp_second_z(rsp_second_z),
      .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   // The whole run is bounded; hitting the bound means something hung.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Rounds c * 2^FW / sqrt(s) to the nearest integer, halves away from zero.
   // The search finds the largest m with (2m-1)^2 * s <= c^2 * 2^(2FW+2).
   function automatic logic [FW:0] unit_length(wide_type c, wide_type s);
      wide_type target, trial;
      longint unsigned lo, hi, mid;
      target = (c * c) << (2 * (FW + 1));
      lo = 0;
      hi = longint'(1) << FW;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         trial = wide_type'(2 * mid - 1);
         trial = trial * trial * s;
         if (trial <= target) lo = mid;
         else hi = mid - 1;
      end
      return lo[FW:0];
   endfunction

   function automatic logic signed [FW+1:0] with_sign(logic [FW:0] mag, bit neg);
      logic signed [FW+1:0] v;
      v = {1'b0, mag};
      return neg ? -v : v;
   endfunction

   // Builds the expected normals of one vector.
   function automatic normal_pair_type predict_normals(logic signed [VW-1:0] vx,
                                                       logic signed [VW-1:0] vy,
                                                       logic signed [VW-1:0] vz);
      normal_pair_type r;
      logic signed [VW-1:0] comp [3];
      wide_type mag [3];
      bit neg [3];
      wide_type s1, s2, full;
      int k, a, b;
      comp[0] = vx; comp[1] = vy; comp[2] = vz;
      for (int i = 0; i < 3; i++) begin
         neg[i] = comp[i][VW-1];
         // The most negative value is taken at its true magnitude.
         mag[i] = neg[i] ? wide_type'((longint'(1) << VW) - longint'({1'b0, comp[i]}))
                         : wide_type'(comp[i]);
         r.first[i] = '0;
         r.second[i] = '0;
      end
      r.status = 1'b0;
      if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
         // A zero vector has no direction: status set, all fields zero.
         r.status = 1'b1;
         return r;
      end
      // Strict comparisons: x wins only when below both, then y below z, else z.
      if (mag[0] < mag[1] && mag[0] < mag[2]) k = 0;
      else if (mag[1] < mag[2]) k = 1;
      else k = 2;
      a = (k + 1) % 3;
      b = (k + 2) % 3;
      s1 = mag[a] * mag[a] + mag[b] * mag[b];
      full = s1 + mag[k] * mag[k];
      s2 = s1 * full;
      r.first[k] = '0;
      r.first[a] = with_sign(unit_length(mag[b], s1), neg[b]);
      r.first[b] = with_sign(unit_length(mag[a], s1), !neg[a]);
      r.second[k] = with_sign(unit_length(s1, s2), 1'b1);
      r.second[a] = with_sign(unit_length(mag[a] * mag[k], s2), neg[a] != neg[k]);
      r.second[b] = with_sign(unit_length(mag[b] * mag[k], s2), neg[b] != neg[k]);
      return r;
   endfunction

   // Sends one word; the sender idles for a random number of cycles first, each
   // with the idle percentage, then holds start until the word is accepted.
   task automatic send_vector(logic signed [VW-1:0] vx, logic signed [VW-1:0] vy,
                              logic signed [VW-1:0] vz);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_vec_x <= vx;
      req_vec_y <= vy;
      req_vec_z <= vz;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_pairs.push_back(predict_normals(vx, vy, vz));
   endtask

   // Compares each response word with the oldest expectation.
   always @(posedge clock) begin
      normal_pair_type want;
      logic signed [FW+1:0] got_first [3];
      logic signed [FW+1:0] got_second [3];
      if (!reset && rsp_valid) begin
         got_first[0] = rsp_first_x; got_first[1] = rsp_first_y;
         got_first[2] = rsp_first_z;
         got_second[0] = rsp_second_x; got_second[1] = rsp_second_y;
         got_second[2] = rsp_second_z;
         if (pending_pairs.size() == 0) begin
            $display("%0t: response word with none expected", $time);
            errors++;
         end else begin
            want = pending_pairs.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (got_first[i] !== want.first[i]) begin
                  $display("%0t: first[%0d] expected %0d actual %0d", $time, i,
                           want.first[i], got_first[i]);
                  errors++;
               end
               if (got_second[i] !== want.second[i]) begin
                  $display("%0t: second[%0d] expected %0d actual %0d", $time, i,
                           want.second[i], got_second[i]);
                  errors++;
               end
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
         end
      end
   end

   // Extremes, axes, ties and the zero vector.
   task automatic test_directed;
      logic signed [VW-1:0] maxv, minv;
      maxv = {1'b0, {(VW-1){1'b1}}};
      minv = {1'b1, {(VW-1){1'b0}}};
      idle_pct = 0;
      send_vector(0, 0, 0);
      send_vector(1, 0, 0);
      send_vector(0, -1, 0);
      send_vector(0, 0, 1);
      send_vector(minv, 0, 0);
      send_vector(0, minv, 0);
      send_vector(0, 0, minv);
      send_vector(maxv, maxv, maxv);
      send_vector(minv, minv, minv);
      send_vector(minv, maxv, minv);
      send_vector(-1, -1, -1);
      send_vector(1, 1, 2);
      send_vector(2, 1, 1);
      send_vector(1, 2, 1);
      send_vector(-3, 3, 5);
      send_vector(5, -3, 3);
      send_vector(3, 4, 0);
      send_vector(maxv, 1, -1);
      send_vector(1, -1, maxv);
      send_vector(minv, maxv, 0);
      send_vector(12345, -678, 91011);
      send_vector(-7, 0, 0);
   endtask

   function automatic logic signed [VW-1:0] random_component();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $signed($urandom_range(20)) - 10;
         2: return $signed($urandom_range(2000000)) - 1000000;
         3: return $urandom_range(1) ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   // Random vectors, with forced ties and zero components now and then.
   task automatic test_random(int count, int pct);
      logic signed [VW-1:0] c [3];
      idle_pct = pct;
      repeat (count) begin
         for (int i = 0; i < 3; i++) c[i] = random_component();
         case ($urandom_range(9))
            0: c[$urandom_range(2)] = 0;
            1: c[1] = $urandom_range(1) ? c[0] : -c[0];
            2: c[2] = c[1];
            3: begin
               c[0] = 0; c[1] = 0; c[2] = 0;
            end
            default: ;
         endcase
         send_vector(c[0], c[1], c[2]);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(410, 17);
      test_random(410, 56);
      test_random(410, 0);
      @(negedge clock);
      start <= 1'b0;
      wait (pending_pairs.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
